// ----- design/mbx_pkg.sv -----
// Shared types, constants and codes for the typed message mailbox.
`default_nettype none

package mbx_pkg;

    localparam int PROCESSES = 16;
    localparam int SLOTS     = 8;

    localparam int PID_W  = 4;
    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [7:0] TYPE_NONE = 8'd0;
    localparam logic [7:0] WILDCARD  = 8'd42;

    localparam logic [1:0] KIND_RESET = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef enum logic [2:0] {
        STAT_STORED    = 3'd0,
        STAT_DELIVERED = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_HIT       = 3'd3,
        STAT_WAIT      = 3'd4,
        STAT_BADTYPE   = 3'd5,
        STAT_REJECT    = 3'd6,
        STAT_RESET     = 3'd7
    } status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  sender_id;
        logic [3:0]  target_id;
        logic [7:0]  msg_type;
        logic [31:0] payload;
        logic [15:0] timeout;
    } mbx_in_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  out_sender;
        logic [3:0]  out_receiver;
        logic [7:0]  out_type;
        logic [31:0] out_payload;
        logic [15:0] sleep_ticks;
    } mbx_out_t;

    // one message slot; mtype of zero marks it free
    typedef struct packed {
        logic [3:0]  sender;
        logic [3:0]  receiver;
        logic [7:0]  mtype;
        logic [31:0] payload;
    } slot_t;

    // one memory word: a whole process's mailbox
    typedef struct packed {
        logic [7:0]             wait_type;
        slot_t [SLOTS-1:0]      slots;
    } row_t;

    typedef struct packed {
        logic               free_found;
        logic [SLOT_IW-1:0] free_idx;
        logic               hit_found;
        logic [SLOT_IW-1:0] hit_idx;
    } match_t;

endpackage

`default_nettype wire

// ----- design/mbx_match.sv -----
// Parallel priority match over one mailbox row: first free slot and first type hit.
`default_nettype none

module mbx_match (
    input  mbx_pkg::slot_t [mbx_pkg::SLOTS-1:0] slots,
    input  logic [7:0]                          msg_type,
    output mbx_pkg::match_t                     result
);
    import mbx_pkg::*;

    // scan from the top so the lowest index wins
    always_comb
    begin
        result = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (slots[i].mtype == TYPE_NONE)
            begin
                result.free_found = 1'b1;
                result.free_idx   = SLOT_IW'(i);
            end
            else if (msg_type == WILDCARD || slots[i].mtype == msg_type)
            begin
                result.hit_found = 1'b1;
                result.hit_idx   = SLOT_IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/typed_message_mailbox.sv -----
// Top level of the typed message mailbox: row memory, sequencer and result register.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data  (mbx_in_t)
//  out     | output    | out_valid / out_ready | out_data (mbx_out_t)
//
// In each transaction the process's row is read from the row memory
// on acceptance, then matched, updated and written back in the update state.
// The row memory has a registered read port.
// After reset every row reads as empty through per-row valid flops; no clearing pass.
// A finished result waits in the output register; a new transaction is taken meanwhile,
// but the update cycle stalls while the previous result is still not taken.
`default_nettype none

module typed_message_mailbox (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mbx_pkg::mbx_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mbx_pkg::mbx_out_t out_data
);
    import mbx_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    mbx_in_t                req_reg;
    row_t                   rd_row_reg;
    logic                   rd_valid_reg;
    logic [PROCESSES-1:0]   row_valid_reg, row_valid_next;
    logic                   out_valid_reg;
    mbx_out_t               out_data_reg;

    row_t                   row_mem [PROCESSES];

    row_t                   row_cur;
    row_t                   row_wr;
    logic                   wr_en;
    mbx_out_t               res;
    match_t                 match;
    logic                   out_free;
    logic                   exec_go;
    logic                   in_fire;
    logic                   tgt_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign exec_go   = (state_reg == S_EXEC) && out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // rows not written since reset or since a reset request read as empty
    assign row_cur = rd_valid_reg ? rd_row_reg : '0;
    assign tgt_ok  = (int'(req_reg.target_id) < PROCESSES);

    mbx_match u_match (
        .slots    (row_cur.slots),
        .msg_type (req_reg.msg_type),
        .result   (match)
    );

    always_comb
    begin
        res            = '0;
        res.status     = STAT_REJECT;
        row_wr         = row_cur;
        wr_en          = 1'b0;
        row_valid_next = row_valid_reg;

        if (req_reg.kind == KIND_NONE || !tgt_ok)
        begin
            res.status = STAT_REJECT;
        end
        else if (req_reg.kind == KIND_RESET)
        begin
            res.status = STAT_RESET;
            row_valid_next[req_reg.target_id] = 1'b0;
        end
        else if (req_reg.kind == KIND_SEND)
        begin
            if (req_reg.msg_type == TYPE_NONE)
            begin
                res.status = STAT_REJECT;
            end
            else if (row_cur.wait_type != TYPE_NONE &&
                     (row_cur.wait_type == WILDCARD ||
                      row_cur.wait_type == req_reg.msg_type))
            begin
                row_wr.wait_type = TYPE_NONE;
                wr_en            = 1'b1;
                res.status       = STAT_DELIVERED;
                res.out_sender   = req_reg.sender_id;
                res.out_receiver = req_reg.target_id;
                res.out_type     = req_reg.msg_type;
                res.out_payload  = req_reg.payload;
            end
            else if (match.free_found)
            begin
                row_wr.slots[match.free_idx].sender   = req_reg.sender_id;
                row_wr.slots[match.free_idx].receiver = req_reg.target_id;
                row_wr.slots[match.free_idx].mtype    = req_reg.msg_type;
                row_wr.slots[match.free_idx].payload  = req_reg.payload;
                wr_en      = 1'b1;
                res.status = STAT_STORED;
            end
            else
            begin
                res.status     = STAT_FULL;
                res.out_sender = req_reg.sender_id;
            end
        end
        else
        begin
            if (req_reg.msg_type == TYPE_NONE)
            begin
                res.status = STAT_BADTYPE;
            end
            else if (match.hit_found)
            begin
                res.status       = STAT_HIT;
                res.out_sender   = row_cur.slots[match.hit_idx].sender;
                res.out_receiver = row_cur.slots[match.hit_idx].receiver;
                res.out_type     = row_cur.slots[match.hit_idx].mtype;
                res.out_payload  = row_cur.slots[match.hit_idx].payload;
                row_wr.slots[match.hit_idx].mtype = TYPE_NONE;
                wr_en = 1'b1;
            end
            else
            begin
                row_wr.wait_type = req_reg.msg_type;
                wr_en            = 1'b1;
                res.status       = STAT_WAIT;
                res.sleep_ticks  = req_reg.timeout;
            end
        end

        if (wr_en)
        begin
            row_valid_next[req_reg.target_id] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // row memory: one read port, one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (exec_go && wr_en)
        begin
            row_mem[req_reg.target_id] <= row_wr;
        end
        if (in_fire)
        begin
            rd_row_reg <= row_mem[in_data.target_id];
            req_reg    <= in_data;
        end
        if (exec_go)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                rd_valid_reg <= row_valid_reg[in_data.target_id];
            end
            if (exec_go)
            begin
                row_valid_reg <= row_valid_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not enter the update cycle");

    a_write_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && wr_en) |-> (req_reg.kind == KIND_SEND || req_reg.kind == KIND_READ))
        else $error("row write-back for a transaction that must not change the row");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without an update cycle");

    a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !out_free) |=> (state_reg == S_EXEC))
        else $error("update cycle left while the result register was occupied");

endmodule

`default_nettype wire
